@@ hdl/pidsc_pkg.sv @@
// Shared types, widths and constants of the PID speed controller.
package pidsc_pkg;

	// Shared multiplier operand and product widths
	localparam int MulAW = 18;
	localparam int MulBW = 33;
	localparam int MulPW = MulAW + MulBW;

	// Accumulator width of the datapath
	localparam int AccW = 57;

	// Configuration register indexes
	localparam logic [2:0] CFG_MODE    = 3'd0;
	localparam logic [2:0] CFG_KP      = 3'd1;
	localparam logic [2:0] CFG_KI      = 3'd2;
	localparam logic [2:0] CFG_KD      = 3'd3;
	localparam logic [2:0] CFG_INT_UP  = 3'd4;
	localparam logic [2:0] CFG_INT_LO  = 3'd5;
	localparam logic [2:0] CFG_DRV_UP  = 3'd6;
	localparam logic [2:0] CFG_DRV_LO  = 3'd7;

	// Mode codes
	localparam logic MODE_FULL   = 1'b0;
	localparam logic MODE_SIMPLE = 1'b1;

	// Filter factors, unsigned Q0.15
	localparam logic [14:0] ALPHA_FULL    = 15'd29491;
	localparam logic [14:0] NALPHA_FULL   = 15'd3277;
	localparam logic [14:0] ALPHA_SIMPLE  = 15'd16384;
	localparam logic [14:0] NALPHA_SIMPLE = 15'd16384;

	// Error thresholds
	localparam logic signed [16:0] DEADBAND   = 17'sd5;
	localparam logic signed [16:0] SEP_FULL   = 17'sd50;
	localparam logic signed [16:0] SEP_SIMPLE = 17'sd1000;

	// Output offset of the full mode, Q.8
	localparam logic signed [AccW-1:0] OFFSET_Q8 = 57'sd1280;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] kp;
		logic signed [15:0] ki;
		logic signed [15:0] kd;
		logic signed [31:0] int_up;
		logic signed [31:0] int_lo;
		logic signed [15:0] drv_up;
		logic signed [15:0] drv_lo;
	} cfg_regs_t;

	typedef struct packed {
		logic                    en;
		logic signed [MulAW-1:0] a;
		logic signed [MulBW-1:0] b;
	} mul_req_t;

endpackage

@@ hdl/pidsc_cfg_regs.sv @@
// Configuration register file of the PID speed controller.
module pidsc_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	output pidsc_pkg::cfg_regs_t  regs
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.mode   <= pidsc_pkg::MODE_FULL;
			regs.kp     <= 16'sd0;
			regs.ki     <= 16'sd0;
			regs.kd     <= 16'sd0;
			regs.int_up <= 32'sd20000;
			regs.int_lo <= -32'sd20000;
			regs.drv_up <= 16'sd100;
			regs.drv_lo <= -16'sd100;
		end else if (cfg_valid) begin
			case (cfg_index)
				pidsc_pkg::CFG_MODE:   regs.mode   <= cfg_data[0];
				pidsc_pkg::CFG_KP:     regs.kp     <= $signed(cfg_data[15:0]);
				pidsc_pkg::CFG_KI:     regs.ki     <= $signed(cfg_data[15:0]);
				pidsc_pkg::CFG_KD:     regs.kd     <= $signed(cfg_data[15:0]);
				pidsc_pkg::CFG_INT_UP: regs.int_up <= $signed(cfg_data);
				pidsc_pkg::CFG_INT_LO: regs.int_lo <= $signed(cfg_data);
				pidsc_pkg::CFG_DRV_UP: regs.drv_up <= $signed(cfg_data[15:0]);
				pidsc_pkg::CFG_DRV_LO: regs.drv_lo <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/pidsc_mul.sv @@
// Shared signed multiplier with registered product.
module pidsc_mul (
	input  logic                                   clk,
	input  pidsc_pkg::mul_req_t                    req,
	output logic signed [pidsc_pkg::MulPW-1:0]     prod_q
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= pidsc_pkg::MulPW'(req.a * req.b);
		end
	end

endmodule

@@ hdl/pid_speed_controller_core.sv @@
// Top level of the PID speed controller: sequencer and accumulator datapath.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+------------------------------
//  in      | in_valid, in_ready, target, actual        | one control tick item
//  out     | out_valid, out_ready, drive, in_deadband, | one drive item per tick
//          | clamped                                   |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// Items are taken one at a time; a deadband item skips from the integral sum straight to
// the output offset. The single shared 18x33 multiplier and the one accumulator adder
// are stepped by the sequencer through the filter and drive sums in turn.
// in_ready is high only while the sequencer is idle; a result waiting in the output
// register does not block acceptance, but the final step holds until it is taken.
// Reset clears the controller state (previous error, integral, filtered derivative)
// and loads the register defaults; cfg_ready is always high.
module pid_speed_controller_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] target,
	input  logic signed [15:0] actual,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] drive,
	output logic               in_deadband,
	output logic               clamped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int AccW = pidsc_pkg::AccW;
	localparam int MulPW = pidsc_pkg::MulPW;
	localparam logic signed [41:0] DfSatHi = 42'sd549755813887;
	localparam logic signed [41:0] DfSatLo = -42'sd549755813888;

	// One-hot sequencer states
	typedef enum logic [15:0] {
		ST_IDLE   = 16'h0001,
		ST_ISUM   = 16'h0002,
		ST_ICLAMP = 16'h0004,
		ST_NAKD   = 16'h0008,
		ST_DE     = 16'h0010,
		ST_DFLO   = 16'h0020,
		ST_DFHI   = 16'h0040,
		ST_DFADD  = 16'h0080,
		ST_DFRND  = 16'h0100,
		ST_KI     = 16'h0200,
		ST_ADDKI  = 16'h0400,
		ST_ADDDF  = 16'h0800,
		ST_OFFS   = 16'h1000,
		ST_CLHI   = 16'h2000,
		ST_CLLO   = 16'h4000,
		ST_ROUND  = 16'h8000
	} state_t;

	state_t                  state_q;
	pidsc_pkg::cfg_regs_t    regs;
	pidsc_pkg::mul_req_t     mreq;
	logic signed [MulPW-1:0] prod_q;

	// Controller state
	logic signed [16:0]      prev_q;
	logic signed [31:0]      integ_q;
	logic signed [39:0]      df_q;

	// Per-item working registers
	logic signed [16:0]      e_q;
	logic signed [17:0]      de_q;
	logic signed [32:0]      isum_q;
	logic                    iclr_q;
	logic signed [AccW-1:0]  acc_q;
	logic                    clip_q;
	logic                    dead_q;

	// Output register
	logic                    out_valid_q;
	logic signed [15:0]      drive_q;
	logic                    dead_out_q;
	logic                    clip_out_q;

	logic                    full;
	logic [14:0]             alpha;
	logic [14:0]             nalpha;
	logic signed [16:0]      sep;
	logic                    e_dead;
	logic                    e_sep;
	logic signed [32:0]      int_up33;
	logic signed [32:0]      int_lo33;
	logic signed [32:0]      isat_hi;
	logic signed [32:0]      isat;
	logic signed [AccW-1:0]  prod_ext;
	logic signed [AccW-1:0]  df_rnd;
	logic signed [41:0]      df_sh;
	logic signed [39:0]      df_sat;
	logic signed [AccW-1:0]  lim_hi;
	logic signed [AccW-1:0]  lim_lo;
	logic signed [AccW-1:0]  acc_rnd8;
	logic                    out_free;
	logic                    accept;

	pidsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	pidsc_mul u_mul (
		.clk    (clk),
		.req    (mreq),
		.prod_q (prod_q)
	);

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign drive       = drive_q;
	assign in_deadband = dead_out_q;
	assign clamped     = clip_out_q;
	assign out_free    = !out_valid_q || out_ready;

	// Mode-dependent constants
	assign full   = (regs.mode == pidsc_pkg::MODE_FULL);
	assign alpha  = full ? pidsc_pkg::ALPHA_FULL : pidsc_pkg::ALPHA_SIMPLE;
	assign nalpha = full ? pidsc_pkg::NALPHA_FULL : pidsc_pkg::NALPHA_SIMPLE;
	assign sep    = full ? pidsc_pkg::SEP_FULL : pidsc_pkg::SEP_SIMPLE;

	// Error classification: deadband and integral separation windows
	assign e_dead = full && (e_q < pidsc_pkg::DEADBAND) && (e_q > -pidsc_pkg::DEADBAND);
	assign e_sep  = (e_q < sep) && (e_q > -sep);

	// Integral clamp: upper limit first, then lower limit wins
	assign int_up33 = 33'(regs.int_up);
	assign int_lo33 = 33'(regs.int_lo);
	assign isat_hi  = (isum_q > int_up33) ? int_up33 : isum_q;
	assign isat     = (isat_hi < int_lo33) ? int_lo33 : isat_hi;

	assign prod_ext = AccW'(prod_q);

	// Filter result: round half up at bit 15, saturate to 40 bits
	assign df_rnd = acc_q + 57'sd16384;
	assign df_sh  = df_rnd[AccW-1:15];
	always_comb begin
		if (df_sh > DfSatHi) begin
			df_sat = DfSatHi[39:0];
		end else if (df_sh < DfSatLo) begin
			df_sat = DfSatLo[39:0];
		end else begin
			df_sat = df_sh[39:0];
		end
	end

	// Drive limits in Q.8
	assign lim_hi   = $signed({{(AccW-24){regs.drv_up[15]}}, regs.drv_up, 8'h00});
	assign lim_lo   = $signed({{(AccW-24){regs.drv_lo[15]}}, regs.drv_lo, 8'h00});
	assign acc_rnd8 = acc_q + 57'sd128;

	// Operand selection of the shared multiplier
	always_comb begin
		mreq.en = 1'b0;
		mreq.a  = '0;
		mreq.b  = '0;
		case (state_q)
			ST_NAKD: begin
				mreq.en = 1'b1;
				mreq.a  = $signed({3'b000, nalpha});
				mreq.b  = 33'(regs.kd);
			end
			ST_DE: begin
				mreq.en = 1'b1;
				mreq.a  = de_q;
				mreq.b  = prod_q[32:0];
			end
			ST_DFLO: begin
				mreq.en = 1'b1;
				mreq.a  = $signed({3'b000, alpha});
				mreq.b  = $signed({13'b0, df_q[19:0]});
			end
			ST_DFHI: begin
				// upper part of the filter state carries the sign
				mreq.en = 1'b1;
				mreq.a  = $signed({3'b000, alpha});
				mreq.b  = 33'($signed(df_q[39:20]));
			end
			ST_DFRND: begin
				mreq.en = 1'b1;
				mreq.a  = 18'(e_q);
				mreq.b  = 33'(regs.kp);
			end
			ST_KI: begin
				mreq.en = 1'b1;
				mreq.a  = 18'(regs.ki);
				mreq.b  = 33'(integ_q);
			end
			default: ;
		endcase
	end

	// Sequencer, controller state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			integ_q     <= '0;
			df_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, else drop the one just taken
			if ((state_q == ST_ROUND) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ISUM;
					end
				end
				ST_ISUM: begin
					prev_q  <= e_q;
					state_q <= e_dead ? ST_OFFS : ST_ICLAMP;
				end
				ST_ICLAMP: begin
					integ_q <= iclr_q ? 32'sd0 : isat[31:0];
					state_q <= ST_NAKD;
				end
				ST_NAKD:  state_q <= ST_DE;
				ST_DE:    state_q <= ST_DFLO;
				ST_DFLO:  state_q <= ST_DFHI;
				ST_DFHI:  state_q <= ST_DFADD;
				ST_DFADD: state_q <= ST_DFRND;
				ST_DFRND: begin
					df_q    <= df_sat;
					state_q <= ST_KI;
				end
				ST_KI:    state_q <= ST_ADDKI;
				ST_ADDKI: state_q <= ST_ADDDF;
				ST_ADDDF: state_q <= ST_OFFS;
				ST_OFFS:  state_q <= ST_CLHI;
				ST_CLHI:  state_q <= ST_CLLO;
				ST_CLLO:  state_q <= ST_ROUND;
				ST_ROUND: begin
					// hold until the previous result is taken
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working datapath: the accumulator adder is shared by the filter and drive sum steps
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					e_q <= 17'(target) - 17'(actual);
				end
			end
			ST_ISUM: begin
				de_q   <= 18'(e_q) - 18'(prev_q);
				isum_q <= 33'(integ_q) + 33'(e_q);
				iclr_q <= (regs.ki == 16'sd0) || !e_sep;
				dead_q <= e_dead;
				clip_q <= 1'b0;
				acc_q  <= '0;
			end
			ST_DFLO:  acc_q <= prod_ext;
			ST_DFHI:  acc_q <= acc_q + prod_ext;
			ST_DFADD: acc_q <= acc_q + $signed({prod_q[36:0], 20'b0});
			ST_KI:    acc_q <= prod_ext;
			ST_ADDKI: acc_q <= acc_q + prod_ext;
			ST_ADDDF: acc_q <= acc_q + AccW'(df_q);
			ST_OFFS: begin
				// push a nonzero sum away from zero in the full mode
				if (full && (acc_q != '0)) begin
					acc_q <= acc_q[AccW-1] ? (acc_q - pidsc_pkg::OFFSET_Q8)
					                       : (acc_q + pidsc_pkg::OFFSET_Q8);
				end
			end
			ST_CLHI: begin
				if (acc_q > lim_hi) begin
					acc_q  <= lim_hi;
					clip_q <= 1'b1;
				end
			end
			ST_CLLO: begin
				if (acc_q < lim_lo) begin
					acc_q  <= lim_lo;
					clip_q <= 1'b1;
				end
			end
			ST_ROUND: begin
				if (out_free) begin
					drive_q    <= acc_rnd8[23:8];
					dead_out_q <= dead_q;
					clip_out_q <= clip_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/pidsc_checker.sv @@
// Port-level checker of the PID speed controller and its bind.
module pidsc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [15:0] drive,
	input logic               out_valid,
	input logic               out_ready,
	input logic               in_deadband,
	input logic               clamped
);

	// A stalled result holds its drive and clamped flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped))
		else $error("stalled result changed");

	// The sequencer is busy right after it takes an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	// No result appears in the cycle after an item is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result too early");

	// Deadband drives zero unless a limit moved it
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_deadband && !clamped |-> drive == 16'sd0)
		else $error("deadband drive not zero");

endmodule

bind pid_speed_controller_core pidsc_checker u_pidsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.drive       (drive),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.in_deadband (in_deadband),
	.clamped     (clamped)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the PID speed controller core: directed table, random ticks.
module tb_top;

	typedef struct packed {
		logic signed [15:0] drive;
		logic               dead;
		logic               clip;
	} drive_res_t;

	typedef struct packed {
		logic               is_cfg;
		logic [2:0]         idx;
		logic [31:0]        data;
		logic signed [15:0] tgt;
		logic signed [15:0] act;
		logic               typed;
		drive_res_t         res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] target;
	logic signed [15:0] actual;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] drive;
	logic               in_deadband;
	logic               clamped;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	// Controller copy: registers and the three state words at block widths
	pidsc_pkg::cfg_regs_t ctl_regs;
	logic signed [16:0]   err_last;
	logic signed [31:0]   err_sum;
	logic signed [39:0]   dterm;

	drive_res_t pending_drives[$];
	dir_row_t   dir_rows[$];
	int         mismatches = 0;
	bit         idle_on = 1'b1;
	bit         stall_on = 1'b1;
	int         stall_left = 0;

	pid_speed_controller_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .target(target), .actual(actual),
		.out_valid(out_valid), .out_ready(out_ready), .drive(drive),
		.in_deadband(in_deadband), .clamped(clamped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(0, 2);
		return $urandom_range(8, 40);
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			pidsc_pkg::CFG_MODE:   ctl_regs.mode   = val[0];
			pidsc_pkg::CFG_KP:     ctl_regs.kp     = val[15:0];
			pidsc_pkg::CFG_KI:     ctl_regs.ki     = val[15:0];
			pidsc_pkg::CFG_KD:     ctl_regs.kd     = val[15:0];
			pidsc_pkg::CFG_INT_UP: ctl_regs.int_up = val;
			pidsc_pkg::CFG_INT_LO: ctl_regs.int_lo = val;
			pidsc_pkg::CFG_DRV_UP: ctl_regs.drv_up = val[15:0];
			pidsc_pkg::CFG_DRV_LO: ctl_regs.drv_lo = val[15:0];
			default: ;
		endcase
	endfunction

	// One control tick: error, deadband, integral, filtered derivative, Q.8 sum, offset, clamp, round
	function automatic drive_res_t pid_drive_calc(input logic signed [15:0] t,
			input logic signed [15:0] a);
		longint e, de, mag, v, s, d, lim, sep, al, nal, dmax;
		longint kp, ki, kd, iu, il, rnd;
		bit full, dead, clip;
		drive_res_t r;
		kp = ctl_regs.kp;
		ki = ctl_regs.ki;
		kd = ctl_regs.kd;
		iu = ctl_regs.int_up;
		il = ctl_regs.int_lo;
		e = longint'(t) - longint'(a);
		de = e - longint'(err_last);
		mag = (e < 0) ? -e : e;
		full = (ctl_regs.mode == pidsc_pkg::MODE_FULL);
		dead = full && (mag < longint'(pidsc_pkg::DEADBAND));
		clip = 1'b0;
		v = 0;
		err_last = e[16:0];
		if (!dead) begin
			sep = full ? longint'(pidsc_pkg::SEP_FULL) : longint'(pidsc_pkg::SEP_SIMPLE);
			al = full ? longint'(pidsc_pkg::ALPHA_FULL) : longint'(pidsc_pkg::ALPHA_SIMPLE);
			nal = full ? longint'(pidsc_pkg::NALPHA_FULL)
			           : longint'(pidsc_pkg::NALPHA_SIMPLE);
			// Separate or disable: drop the integral
			if (ki == 0 || mag >= sep) begin
				err_sum = '0;
			end else begin
				s = longint'(err_sum) + e;
				if (s > iu) s = iu;
				if (s < il) s = il;
				err_sum = s[31:0];
			end
			dmax = (64'sd1 <<< 39) - 1;
			d = (nal * kd * de + al * longint'(dterm) + (64'sd1 <<< 14)) >>> 15;
			if (d > dmax) d = dmax;
			if (d < -dmax - 1) d = -dmax - 1;
			dterm = d[39:0];
			v = kp * e + ki * longint'(err_sum) + longint'(dterm);
		end
		if (full) begin
			if (v > 0) v = v + longint'(pidsc_pkg::OFFSET_Q8);
			else if (v < 0) v = v - longint'(pidsc_pkg::OFFSET_Q8);
		end
		lim = longint'(ctl_regs.drv_up) * 256;
		if (v > lim) begin
			v = lim;
			clip = 1'b1;
		end
		lim = longint'(ctl_regs.drv_lo) * 256;
		if (v < lim) begin
			v = lim;
			clip = 1'b1;
		end
		rnd = (v + 128) >>> 8;
		r.drive = rnd[15:0];
		r.dead = dead;
		r.clip = clip;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [31:0] val);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = val;
		return r;
	endfunction

	function automatic dir_row_t tick_row(input int t, input int a);
		dir_row_t r;
		r = '0;
		r.tgt = t[15:0];
		r.act = a[15:0];
		return r;
	endfunction

	function automatic dir_row_t tick_chk(input int t, input int a, input int d,
			input bit db, input bit cl);
		dir_row_t r;
		r = tick_row(t, a);
		r.typed = 1'b1;
		r.res.drive = d[15:0];
		r.res.dead = db;
		r.res.clip = cl;
		return r;
	endfunction

	// Drop valid and wait until every expected drive item has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold valid across back-to-back items; lower it only when a gap is taken
	task automatic send_tick(input logic signed [15:0] t, input logic signed [15:0] a,
			input logic typed, input drive_res_t fixed);
		int gap;
		drive_res_t calc;
		gap = idle_on ? gap_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		target <= t;
		actual <= a;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		calc = pid_drive_calc(t, a);
		pending_drives.push_back(typed ? fixed : calc);
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3, 4: return 16'($urandom_range(0, 1024) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_limit(input bit upper, input int wide, input int tight);
		case ($urandom_range(0, 5))
			0: return upper ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return upper ? 32'($urandom_range(0, tight)) : 32'(0 - $urandom_range(0, tight));
			2: return $urandom;
			default: return upper ? 32'(wide) : 32'(-wide);
		endcase
	endfunction

	// Receiver side: random stalls, switched off for whole phases
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_on && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left <= gap_len();
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		drive_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drives.size() == 0) begin
				$display("%0t: unexpected drive item, expected none, got drive=%0d", $time,
					drive);
				mismatches++;
			end else begin
				want = pending_drives.pop_front();
				if (drive !== want.drive) begin
					$display("%0t: drive expected %0d, got %0d", $time, want.drive, drive);
					mismatches++;
				end
				if (in_deadband !== want.dead) begin
					$display("%0t: in_deadband expected %0b, got %0b", $time, want.dead,
						in_deadband);
					mismatches++;
				end
				if (clamped !== want.clip) begin
					$display("%0t: clamped expected %0b, got %0b", $time, want.clip, clamped);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int phase, n, tv, av, dv, span;
		logic [15:0] du, dl;
		arst_n = 1'b0;
		in_valid = 1'b0;
		target = '0;
		actual = '0;
		cfg_valid = 1'b0;
		cfg_index = pidsc_pkg::CFG_MODE;
		cfg_data = '0;
		ctl_regs.mode = pidsc_pkg::MODE_FULL;
		ctl_regs.kp = '0;
		ctl_regs.ki = '0;
		ctl_regs.kd = '0;
		ctl_regs.int_up = 32'sd20000;
		ctl_regs.int_lo = -32'sd20000;
		ctl_regs.drv_up = 16'sd100;
		ctl_regs.drv_lo = -16'sd100;
		err_last = '0;
		err_sum = '0;
		dterm = '0;

		dir_rows = '{
			// Reset defaults: all gains zero, full mode
			tick_chk(0, 0, 0, 1'b1, 1'b0),
			tick_chk(32767, -32768, 0, 1'b0, 1'b0),
			tick_chk(-32768, 32767, 0, 1'b0, 1'b0),
			// Unity proportional gain: saturate both ways, deadband edges
			cfg_row(pidsc_pkg::CFG_KP, 32'd256),
			tick_chk(32767, -32768, 100, 1'b0, 1'b1),
			tick_chk(-32768, 32767, -100, 1'b0, 1'b1),
			tick_chk(4, 0, 0, 1'b1, 1'b0),
			tick_chk(-4, 0, 0, 1'b1, 1'b0),
			tick_chk(5, 0, 10, 1'b0, 1'b0),
			tick_chk(0, 5, -10, 1'b0, 1'b0),
			// Integral accumulates, then separates at the threshold
			cfg_row(pidsc_pkg::CFG_KI, 32'd256),
			tick_chk(10, 0, 25, 1'b0, 1'b0),
			tick_chk(10, 0, 35, 1'b0, 1'b0),
			tick_chk(50, 0, 55, 1'b0, 1'b0),
			cfg_row(pidsc_pkg::CFG_INT_UP, 32'd3),
			tick_chk(10, 0, 18, 1'b0, 1'b0),
			// Crossed integral limits at the extremes: lower wins
			cfg_row(pidsc_pkg::CFG_INT_UP, 32'h8000_0000),
			cfg_row(pidsc_pkg::CFG_INT_LO, 32'h7FFF_FFFF),
			tick_row(10, 0),
			cfg_row(pidsc_pkg::CFG_INT_UP, 32'h7FFF_FFFF),
			cfg_row(pidsc_pkg::CFG_INT_LO, 32'h8000_0000),
			// Simple mode with widest drive range and extreme derivative gain
			cfg_row(pidsc_pkg::CFG_KD, 32'h0000_7FFF),
			cfg_row(pidsc_pkg::CFG_MODE, 32'(pidsc_pkg::MODE_SIMPLE)),
			cfg_row(pidsc_pkg::CFG_DRV_UP, 32'h0000_7FFF),
			cfg_row(pidsc_pkg::CFG_DRV_LO, 32'h0000_8000),
			tick_row(-32768, 32767),
			tick_row(32767, -32768),
			tick_row(999, 0),
			tick_row(0, 999),
			cfg_row(pidsc_pkg::CFG_KP, 32'h0000_8000),
			cfg_row(pidsc_pkg::CFG_KI, 32'd0),
			cfg_row(pidsc_pkg::CFG_KD, 32'h0000_8000),
			tick_row(32767, -32768),
			tick_row(1000, 0),
			// Crossed drive limits: lower limit wins, in and out of the deadband
			cfg_row(pidsc_pkg::CFG_KP, 32'd0),
			cfg_row(pidsc_pkg::CFG_KD, 32'd0),
			cfg_row(pidsc_pkg::CFG_DRV_UP, 32'hFFFF_FFF6),
			cfg_row(pidsc_pkg::CFG_DRV_LO, 32'd10),
			tick_chk(0, 0, 10, 1'b0, 1'b1),
			cfg_row(pidsc_pkg::CFG_MODE, 32'(pidsc_pkg::MODE_FULL)),
			tick_chk(0, 0, 10, 1'b1, 1'b1)
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				send_tick(dir_rows[i].tgt, dir_rows[i].act, dir_rows[i].typed,
					dir_rows[i].res);
		end

		// Random phases: fresh register set each time, every third phase without idling
		for (phase = 0; phase < 12; phase++) begin
			write_reg(pidsc_pkg::CFG_MODE, 32'(phase % 2));
			write_reg(pidsc_pkg::CFG_KP, 32'(pick_gain()));
			write_reg(pidsc_pkg::CFG_KI, 32'(pick_gain()));
			write_reg(pidsc_pkg::CFG_KD, 32'(pick_gain()));
			write_reg(pidsc_pkg::CFG_INT_UP, pick_limit(1'b1, 20000, 300));
			write_reg(pidsc_pkg::CFG_INT_LO, pick_limit(1'b0, 20000, 300));
			du = 16'(pick_limit(1'b1, 100, 500));
			dl = 16'(pick_limit(1'b0, 100, 500));
			write_reg(pidsc_pkg::CFG_DRV_UP, 32'(du));
			write_reg(pidsc_pkg::CFG_DRV_LO, 32'(dl));
			idle_on = (phase % 3 != 2);
			stall_on = idle_on;
			span = (phase % 2 == 1) ? 1100 : 60;
			for (n = 0; n < 150; n++) begin
				tv = int'($urandom_range(0, 65535)) - 32768;
				if ($urandom_range(0, 9) < 3) begin
					av = int'($urandom_range(0, 65535)) - 32768;
				end else begin
					// Keep the error near the deadband and separation thresholds
					dv = int'($urandom_range(0, 2 * span)) - span;
					av = tv - dv;
					if (av > 32767 || av < -32768) av = tv + dv;
				end
				send_tick(tv[15:0], av[15:0], 1'b0, '0);
			end
		end

		idle_on = 1'b1;
		stall_on = 1'b1;
		settle();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
